// ----- src/lrp_pkg.sv -----
// Package for the LR recognizer: payload structs, table sizes, codes.
// Used by every module in src except lrp_ram.
package lrp_pkg;

  localparam int MAX_STATES   = 512;
  localparam int MAX_TOKENS   = 64;
  localparam int MAX_SYMBOLS  = 64;
  localparam int MAX_RULES    = 256;
  localparam int STACK_DEPTH  = 256;
  localparam int MAX_RHS      = 15;
  localparam int REDUCE_LIMIT = 4096;
  localparam int ACT_SIZE     = MAX_STATES * MAX_TOKENS;
  localparam int GOTO_SIZE    = MAX_STATES * MAX_SYMBOLS;
  localparam int AW           = $clog2(ACT_SIZE);
  localparam int GW           = $clog2(GOTO_SIZE);
  localparam int RW           = $clog2(MAX_RULES);
  localparam int SW           = $clog2(STACK_DEPTH);
  localparam int QDEPTH       = 2;
  localparam int QW           = $clog2(QDEPTH);
  localparam int CW           = $clog2(QDEPTH + 1);

  localparam logic [1:0] FN_ACT = 2'd0, FN_GOTO = 2'd1, FN_RULE = 2'd2, FN_TOK = 2'd3;
  localparam logic [1:0] AT_ERR = 2'd0, AT_SHIFT = 2'd1, AT_RED = 2'd2, AT_ACC = 2'd3;
  localparam logic [1:0] ST_ACC = 2'd0, ST_INC = 2'd1, ST_SYN = 2'd2;
  localparam logic [2:0] REG_NS = 3'd0, REG_NT = 3'd1, REG_NSYM = 3'd2,
                         REG_NR = 3'd3, REG_EOF = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [14:0] index;
    logic [11:0] entry;
    logic [5:0]  token;
    logic        last_token;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] end_position;
  } out_item_t;

  // classified token passed from front to back
  typedef struct packed {
    logic [5:0] token;
    logic       last;
    logic       in_range;
    logic       is_eof;
  } tok_cmd_t;

endpackage

// ----- src/lrp_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module lrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- src/lrp_front.sv -----
// Front end: accepts items, performs table writes, classifies tokens
// into a short queue for the back end. Depends on lrp_pkg.
module lrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrp_pkg::in_item_t in_data,
  input  logic [6:0]        nt,
  input  logic [6:0]        eof_tok,
  input  logic              back_idle,
  output logic              act_we,
  output logic              goto_we,
  output logic              rule_we,
  output logic [14:0]       wr_addr,
  output logic [11:0]       wr_data,
  output logic              q_valid,
  input  logic              q_pop,
  output lrp_pkg::tok_cmd_t q_head
);
  import lrp_pkg::*;

  tok_cmd_t      q [QDEPTH];
  logic [QW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic [6:0]    tok7;

  // table writes wait until queued tokens are done so a parse never sees them early
  assign in_ready = (in_data.func == FN_TOK) ? (count != CW'(QDEPTH)) :
                    (count == '0 && back_idle);
  assign push     = in_valid && in_ready && in_data.func == FN_TOK;
  assign tok7     = {1'b0, in_data.token};
  assign wr_addr  = in_data.index;
  assign wr_data  = in_data.entry;
  assign act_we   = in_valid && in_ready && in_data.func == FN_ACT &&
                    {2'b0, in_data.index} < 17'(ACT_SIZE);
  assign goto_we  = in_valid && in_ready && in_data.func == FN_GOTO &&
                    {2'b0, in_data.index} < 17'(GOTO_SIZE);
  assign rule_we  = in_valid && in_ready && in_data.func == FN_RULE &&
                    {2'b0, in_data.index} < 17'(MAX_RULES);
  assign q_valid  = count != '0;
  assign q_head   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q[wr_ptr] <= '{token: in_data.token, last: in_data.last_token,
                       in_range: tok7 != 7'd0 && tok7 <= nt,
                       is_eof: tok7 == eof_tok};
        wr_ptr <= (wr_ptr == QW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) rd_ptr <= (rd_ptr == QW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(push) - CW'(q_pop);
    end
  end
endmodule

// ----- src/lrp_back.sv -----
// Back end: runs shift/reduce over the state stack using the action, goto
// and rule tables. Depends on lrp_pkg and lrp_ram.
module lrp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  lrp_pkg::tok_cmd_t  q_head,
  output logic               back_idle,
  input  logic               act_we,
  input  logic               goto_we,
  input  logic               rule_we,
  input  logic [14:0]        wr_addr,
  input  logic [11:0]        wr_data,
  input  logic [9:0]         ns,
  input  logic [6:0]         nt,
  input  logic [6:0]         nsym,
  input  logic [8:0]         nr,
  output logic               out_valid,
  input  logic               out_ready,
  output lrp_pkg::out_item_t out_data
);
  import lrp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ACT, S_DEC, S_RULE, S_POP, S_EXP, S_GOTO, S_OUT
  } state_t;
  state_t state;

  logic [SW:0]   sp;
  logic [8:0]    top;
  logic          finished;
  logic [15:0]   tcount;
  logic [12:0]   reduces;
  tok_cmd_t      cur;
  logic [3:0]    rhs;
  logic [6:0]    lhs;

  logic [AW-1:0] act_raddr;
  logic [11:0]   act_rdata;
  logic [GW-1:0] goto_raddr;
  logic [9:0]    goto_rdata;
  logic [RW-1:0] rule_raddr;
  logic [10:0]   rule_rdata;
  logic          stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [8:0]    stk_wdata, stk_rdata;
  logic [8:0]    exposed;

  logic [15:0]   act_prod, goto_prod;
  logic [1:0]    atype;
  logic [9:0]    aval;

  lrp_ram #(.WIDTH(12), .DEPTH(ACT_SIZE)) u_act (
    .clk, .we(act_we), .waddr(wr_addr[AW-1:0]), .wdata(wr_data),
    .raddr(act_raddr), .rdata(act_rdata));
  lrp_ram #(.WIDTH(10), .DEPTH(GOTO_SIZE)) u_goto (
    .clk, .we(goto_we), .waddr(wr_addr[GW-1:0]), .wdata(wr_data[9:0]),
    .raddr(goto_raddr), .rdata(goto_rdata));
  lrp_ram #(.WIDTH(11), .DEPTH(MAX_RULES)) u_rule (
    .clk, .we(rule_we), .waddr(wr_addr[RW-1:0]), .wdata(wr_data[10:0]),
    .raddr(rule_raddr), .rdata(rule_rdata));
  lrp_ram #(.WIDTH(9), .DEPTH(STACK_DEPTH)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  // bottom entry is always state 0 and is never taken from memory
  assign exposed    = (sp == (SW+1)'(1)) ? 9'd0 : stk_rdata;

  // top of stack is cached in a register; reads only needed after pops
  assign act_prod   = 16'(top) * 16'(nt) + 16'(cur.token) - 16'd1;
  assign goto_prod  = 16'(exposed) * 16'(nsym) + 16'(lhs) - 16'd1;
  assign act_raddr  = act_prod[AW-1:0];
  assign goto_raddr = goto_prod[GW-1:0];
  assign rule_raddr = aval[RW-1:0];
  assign atype      = cur.in_range ? act_rdata[11:10] : AT_ERR;
  assign aval       = act_rdata[9:0];
  assign stk_raddr  = SW'(sp - (SW+1)'(rhs) - (SW+1)'(1));
  assign q_pop      = state == S_IDLE && q_valid && !out_valid;
  assign back_idle  = state == S_IDLE;

  // stack writes: each new top state is written to memory on push
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp[SW-1:0];
    stk_wdata = 9'd0;
    if (state == S_DEC && atype == AT_SHIFT && sp < (SW+1)'(STACK_DEPTH)) begin
      stk_we = 1'b1; stk_wdata = aval[8:0];
    end else if (state == S_GOTO) begin
      stk_we = 1'b1; stk_wdata = goto_rdata[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= (SW+1)'(1);
      top       <= 9'd0;
      finished  <= 1'b0;
      tcount    <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_pop) begin
          cur     <= q_head;
          reduces <= '0;
          if (finished) begin
            if (q_head.last) begin
              sp <= (SW+1)'(1); top <= 9'd0; finished <= 1'b0; tcount <= 16'd0;
            end
          end else if ({1'b0, top} >= ns) begin
            out_data <= '{status: ST_SYN, end_position: tcount};
            state    <= S_OUT;
          end else begin
            state <= S_ACT;
          end
        end
        S_ACT: state <= S_DEC;
        S_DEC: begin
          unique case (atype)
            AT_SHIFT: begin
              if (sp >= (SW+1)'(STACK_DEPTH)) begin
                out_data <= '{status: ST_SYN, end_position: tcount}; state <= S_OUT;
              end else begin
                sp  <= sp + 1'b1;
                top <= aval[8:0];
                if (tcount != 16'hFFFF) tcount <= tcount + 1'b1;
                if (aval >= ns) begin
                  out_data <= '{status: ST_SYN,
                                end_position: tcount + 16'(tcount != 16'hFFFF)};
                  state <= S_OUT;
                end else if (cur.last) begin
                  out_data <= '{status: ST_INC,
                                end_position: tcount + 16'(tcount != 16'hFFFF)};
                  state <= S_OUT;
                end else begin
                  state <= S_IDLE;
                end
              end
            end
            AT_RED: begin
              if ({1'b0, aval} >= 11'(nr) || reduces >= 13'(REDUCE_LIMIT)) begin
                out_data <= '{status: ST_SYN, end_position: tcount}; state <= S_OUT;
              end else begin
                reduces <= reduces + 1'b1;
                state   <= S_RULE;
              end
            end
            AT_ACC: begin
              out_data <= '{status: ST_ACC, end_position: tcount}; state <= S_OUT;
            end
            default: begin
              out_data <= '{status: cur.is_eof ? ST_INC : ST_SYN, end_position: tcount};
              state    <= S_OUT;
            end
          endcase
        end
        S_RULE: begin
          rhs <= rule_rdata[3:0];
          lhs <= rule_rdata[10:4];
          if ((SW+1)'(rule_rdata[3:0]) >= sp) begin
            out_data <= '{status: ST_SYN, end_position: tcount}; state <= S_OUT;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          // exposed state read from memory, or top itself when nothing popped
          sp    <= sp - (SW+1)'(rhs);
          state <= S_EXP;
        end
        S_EXP: begin
          if ({1'b0, exposed} >= ns) begin
            out_data <= '{status: ST_SYN, end_position: tcount}; state <= S_OUT;
          end else begin
            state <= S_GOTO;
          end
        end
        S_GOTO: begin
          state <= S_OUT;
          out_data <= '{status: ST_SYN, end_position: tcount};
          if (lhs == 7'd0 || lhs > nsym || sp >= (SW+1)'(STACK_DEPTH)) begin
            state <= S_OUT;
          end else begin
            top   <= goto_rdata[8:0];
            sp    <= sp + 1'b1;
            state <= (goto_rdata >= ns) ? S_OUT : S_ACT;
          end
        end
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          if (cur.last) begin
            sp <= (SW+1)'(1); top <= 9'd0; finished <= 1'b0; tcount <= 16'd0;
          end else begin
            finished <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/lr_parse_recognizer_core.sv -----
// Table-driven LR recognizer. A token is queued at transfer and popped once the
// back end is idle; a shift runs pop, action read and decide, and each reduce
// adds rule read, pop, stack read, goto read and next action read. A result is
// registered via S_OUT after the deciding cycle; the next token waits until it
// is taken. Table loads wait for an empty token queue and an idle back end.
// Synchronous reset: registers 512/64/64/256/1, stack of state 0, tables kept.
module lr_parse_recognizer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lrp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data
);
  import lrp_pkg::*;

  logic [9:0] ns_r;
  logic [6:0] nt_r, nsym_r, eof_r;
  logic [8:0] nr_r;
  logic [9:0] ns;
  logic [6:0] nt, nsym;
  logic [8:0] nr;
  logic act_we, goto_we, rule_we, q_valid, q_pop, back_idle;
  logic [14:0] wr_addr;
  logic [11:0] wr_data;
  tok_cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      ns_r <= 10'd512; nt_r <= 7'd64; nsym_r <= 7'd64; nr_r <= 9'd256; eof_r <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NS:   ns_r   <= cfg_data;
        REG_NT:   nt_r   <= cfg_data[6:0];
        REG_NSYM: nsym_r <= cfg_data[6:0];
        REG_NR:   nr_r   <= cfg_data[8:0];
        REG_EOF:  eof_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign ns   = (ns_r > 10'(MAX_STATES)) ? 10'(MAX_STATES) : ns_r;
  assign nt   = (nt_r > 7'(MAX_TOKENS)) ? 7'(MAX_TOKENS) : nt_r;
  assign nsym = (nsym_r > 7'(MAX_SYMBOLS)) ? 7'(MAX_SYMBOLS) : nsym_r;
  assign nr   = (nr_r > 9'(MAX_RULES)) ? 9'(MAX_RULES) : nr_r;

  lrp_front u_front (.clk, .rst, .in_valid, .in_ready, .in_data, .nt,
    .eof_tok(eof_r), .back_idle, .act_we, .goto_we, .rule_we, .wr_addr, .wr_data,
    .q_valid, .q_pop, .q_head);

  lrp_back u_back (.clk, .rst, .q_valid, .q_pop, .q_head, .back_idle, .act_we,
    .goto_we, .rule_we, .wr_addr, .wr_data, .ns, .nt, .nsym, .nr, .out_valid,
    .out_ready, .out_data);

`ifndef SYNTHESIS
  a_out_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !out_valid) else $error("pop while result pending");
`endif
endmodule
